// ===== rtl/glnfa_pkg.sv =====
`default_nettype none
package glnfa_pkg;

  localparam int POSITIONS   = 64;
  localparam int SYMBOL_BITS = 8;
  localparam int ROW_W       = 64;
  localparam int POS_W       = 6;
  localparam int LABEL_W     = 8;
  localparam int COUNT_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CELLS       = (POSITIONS < ROW_W) ? POSITIONS : ROW_W;

  typedef enum logic [1:0] {
    REQ_FOLLOW = 2'd0,
    REQ_LABEL  = 2'd1,
    REQ_SYMBOL = 2'd2,
    REQ_EMPTY  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_COUNT = 2'd0,
    CFG_FIRST     = 2'd1,
    CFG_LAST      = 2'd2,
    CFG_EMPTY     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] used_mask;
    logic [ROW_W-1:0] first_mask;
    logic [ROW_W-1:0] last_mask;
    logic             empty_accepted;
  } cfg_t;

  typedef struct packed {
    req_t               req;
    logic [POS_W-1:0]   position;
    logic [ROW_W-1:0]   row_bits;
    logic [LABEL_W-1:0] label_value;
    logic [LABEL_W-1:0] symbol;
    logic               last_symbol;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/glushkov_nfa_matcher_unit.sv =====
// Throughput: one request per cycle, symbols and table loads alike, but a word end
// waits on a held result. Both request and result are registered.
// The position update is one parallel pass over all follow rows and labels.
// Reset clears configuration, active positions, word state and both valids.
// Follow rows and labels are not reset and must be loaded before use.
`default_nettype none
module glushkov_nfa_matcher_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       req_type,
  input  wire logic [glnfa_pkg::POS_W-1:0]      position,
  input  wire logic [glnfa_pkg::ROW_W-1:0]      row_bits,
  input  wire logic [glnfa_pkg::LABEL_W-1:0]    label_value,
  input  wire logic [glnfa_pkg::LABEL_W-1:0]    symbol,
  input  wire logic                             last_symbol,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  accepted,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [glnfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [glnfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import glnfa_pkg::*;

  cfg_t             cfg;
  item_t            item;
  logic             item_valid;
  logic             fire;
  logic             accepted_next;
  logic             word_end;

  assign cfg_ready = 1'b1;

  glnfa_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance unless a result is due and the result register is still held
  assign fire     = item_valid && (!word_end || !out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.req         <= req_t'(req_type);
      item.position    <= position;
      item.row_bits    <= row_bits;
      item.label_value <= label_value;
      item.symbol      <= symbol;
      item.last_symbol <= last_symbol;
    end
  end

  glnfa_matcher_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (item),
    .cfg           (cfg),
    .accepted_next (accepted_next),
    .word_end      (word_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && word_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word_end) begin
      accepted <= accepted_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (fire && word_end) |=> out_valid)
    else $error("result lost at word end");

  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !fire) |=> (item_valid && $stable(item)))
    else $error("held request changed");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(fire && word_end))
    else $error("result overwritten while held");

  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !word_end) |-> fire)
    else $error("load or inner symbol stalled");

endmodule
`default_nettype wire

// ===== rtl/glnfa_cfg.sv =====
`default_nettype none
module glnfa_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [glnfa_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [glnfa_pkg::CFG_DATA_W-1:0] wr_data,
  output glnfa_pkg::cfg_t                       cfg
);
  import glnfa_pkg::*;

  localparam logic [COUNT_W-1:0] CELL_LIM = COUNT_W'(CELLS);

  cfg_t             cfg_reg;
  logic [COUNT_W-1:0] sat_count;
  logic [ROW_W-1:0]   used_next;

  always_comb begin
    sat_count = wr_data[COUNT_W-1:0];
    if (sat_count > CELL_LIM) begin
      sat_count = CELL_LIM;
    end
    for (int i = 0; i < ROW_W; i++) begin
      used_next[i] = (COUNT_W'(i) < sat_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_POS_COUNT: cfg_reg.used_mask      <= used_next;
        CFG_FIRST:     cfg_reg.first_mask     <= wr_data[ROW_W-1:0];
        CFG_LAST:      cfg_reg.last_mask      <= wr_data[ROW_W-1:0];
        CFG_EMPTY:     cfg_reg.empty_accepted <= wr_data[0];
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/glnfa_pos_array.sv =====
`default_nettype none
module glnfa_pos_array (
  input  wire logic                          clk,
  input  wire logic                          wr_follow,
  input  wire logic                          wr_label,
  input  wire logic [glnfa_pkg::POS_W-1:0]   position,
  input  wire logic [glnfa_pkg::ROW_W-1:0]   row_bits,
  input  wire logic [glnfa_pkg::LABEL_W-1:0] label_value,
  input  wire logic [glnfa_pkg::LABEL_W-1:0] symbol,
  input  wire logic [glnfa_pkg::ROW_W-1:0]   active,
  output logic      [glnfa_pkg::ROW_W-1:0]   follow_union,
  output logic      [glnfa_pkg::ROW_W-1:0]   label_hits
);
  import glnfa_pkg::*;

  localparam logic [POS_W:0] CELL_LIM = (POS_W+1)'(CELLS);

  logic [ROW_W-1:0]       follow_rows [CELLS];
  logic [SYMBOL_BITS-1:0] labels      [CELLS];
  logic [CELLS-1:0]       columns     [ROW_W];
  logic                   in_range;

  assign in_range = ({1'b0, position} < CELL_LIM);

  genvar i, j;
  generate
    for (i = 0; i < CELLS; i++) begin : g_cell
      always_ff @(posedge clk) begin
        if (in_range && (position == POS_W'(i))) begin
          if (wr_follow) begin
            follow_rows[i] <= row_bits;
          end
          if (wr_label) begin
            labels[i] <= label_value[SYMBOL_BITS-1:0];
          end
        end
      end
      assign label_hits[i] = (labels[i] == symbol[SYMBOL_BITS-1:0]);
      for (j = 0; j < ROW_W; j++) begin : g_col
        assign columns[j][i] = follow_rows[i][j];
      end
    end
    if (CELLS < ROW_W) begin : g_pad
      assign label_hits[ROW_W-1:CELLS] = '0;
    end
    for (j = 0; j < ROW_W; j++) begin : g_union
      assign follow_union[j] = |(columns[j] & active[CELLS-1:0]);
    end
  endgenerate

endmodule
`default_nettype wire

// ===== rtl/glnfa_matcher_core.sv =====
`default_nettype none
module glnfa_matcher_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  glnfa_pkg::item_t          item,
  input  glnfa_pkg::cfg_t           cfg,
  output logic                      accepted_next,
  output logic                      word_end
);
  import glnfa_pkg::*;

  logic [ROW_W-1:0] follow_union;
  logic [ROW_W-1:0] label_hits;
  logic [ROW_W-1:0] active_next;
  logic [ROW_W-1:0] active;
  logic [ROW_W-1:0] active_used;
  logic             inside_word;
  logic             is_symbol;

  assign active_used = active & cfg.used_mask;

  glnfa_pos_array u_pos_array (
    .clk          (clk),
    .wr_follow    (fire && (item.req == REQ_FOLLOW)),
    .wr_label     (fire && (item.req == REQ_LABEL)),
    .position     (item.position),
    .row_bits     (item.row_bits),
    .label_value  (item.label_value),
    .symbol       (item.symbol),
    .active       (active_used),
    .follow_union (follow_union),
    .label_hits   (label_hits)
  );

  assign is_symbol   = (item.req == REQ_SYMBOL);
  assign active_next = (inside_word ? follow_union : cfg.first_mask)
                       & label_hits & cfg.used_mask;
  assign word_end    = (is_symbol && item.last_symbol) || (item.req == REQ_EMPTY);

  always_comb begin
    if (item.req == REQ_EMPTY) begin
      accepted_next = cfg.empty_accepted;
    end else begin
      accepted_next = |(active_next & cfg.last_mask & cfg.used_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      inside_word <= 1'b0;
    end else if (fire) begin
      if (word_end) begin
        active      <= '0;
        inside_word <= 1'b0;
      end else if (is_symbol) begin
        active      <= active_next;
        inside_word <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !inside_word |-> (active == '0))
    else $error("active positions outside a word");

  assert property (@(posedge clk) disable iff (rst)
    (fire && word_end) |=> (!inside_word && (active == '0)))
    else $error("word state not cleared at word end");

  assert property (@(posedge clk) disable iff (rst)
    (fire && is_symbol && !item.last_symbol) |=> inside_word)
    else $error("word not opened by inner symbol");

endmodule
`default_nettype wire
